>>> rtl/pal_pkg.sv
// Package for the positional array list: field widths, operation and status codes,
// item payload types and parameter defaults. No dependencies.
`default_nettype none

package pal_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 10;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam int DEPTH_DEFAULT       = 512;
    localparam int ENTRY_WIDTH_DEFAULT = 16;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REM_END   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REM_POS   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd6;
    // Kind with no operation behind it; it leaves the list untouched.
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 3'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] entry_value;
    } pal_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  entry_out;
        logic [COUNT_W-1:0]  count;
    } pal_rsp_t;

endpackage

`default_nettype wire

>>> rtl/pal_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on pal_pkg for the payload types.
`default_nettype none

interface pal_req_if;
    logic               valid;
    logic               ready;
    pal_pkg::pal_req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pal_rsp_if;
    logic               valid;
    logic               ready;
    pal_pkg::pal_rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pal_ram.sv
// Entry memory of the list: one write port and one read port with registered read data.
// No package dependency.
`default_nettype none

module pal_ram #(
    parameter int DEPTH       = 512,
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic      [ENTRY_WIDTH-1:0]       rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [ENTRY_WIDTH-1:0]       wr_data
);

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pal_seq.sv
// Operation sequencer: checks each item, moves entries through the memory one per
// cycle, keeps the entry count and holds the response. Depends on pal_pkg and pal_if.
`default_nettype none

module pal_seq #(
    parameter int DEPTH       = 512,
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pal_req_if.sink                           req,
    pal_rsp_if.source                         rsp,
    output logic                              rd_en,
    output logic      [$clog2(DEPTH)-1:0]     rd_addr,
    input  wire logic [ENTRY_WIDTH-1:0]       rd_data,
    output logic                              wr_en,
    output logic      [$clog2(DEPTH)-1:0]     wr_addr,
    output logic      [ENTRY_WIDTH-1:0]       wr_data
);

    import pal_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > POS_W) ? CW : POS_W;
    localparam int WIDE  = (ENTRY_WIDTH > VALUE_W) ? ENTRY_WIDTH : VALUE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [ENTRY_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [CW-1:0]          rd_left_reg, rd_left_next;
    logic                   ret_valid_reg, ret_valid_next;
    logic [AW-1:0]          ret_addr_reg, ret_addr_next;
    logic [ENTRY_WIDTH-1:0] got_reg, got_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    pal_rsp_t               out_data_reg, out_data_next;

    // Item check at acceptance.
    logic [CMPW-1:0]     cnt_ext, pos_ext, p_w, start_w, n_w;
    logic [STATUS_W-1:0] st_w;
    logic                ins_w;
    logic [WIDE-1:0]     val_wide, got_wide;
    logic [CMPW-1:0]     cnt_out_ext;
    logic                full, empty;

    // Class of the operation in progress.
    logic op_ins, op_rem;

    always_comb
    begin
        cnt_ext = CMPW'(cnt_reg);
        pos_ext = CMPW'(req.data.position);
        full    = (cnt_reg == CW'(DEPTH));
        empty   = (cnt_reg == '0);
        p_w     = '0;
        st_w    = STATUS_OK;
        ins_w   = 1'b0;
        unique case (req.data.kind)
            KIND_INS_FRONT:
            begin
                ins_w = 1'b1;
                if (full) st_w = STATUS_FULL;
            end
            KIND_INS_END:
            begin
                ins_w = 1'b1;
                p_w   = cnt_ext;
                if (full) st_w = STATUS_FULL;
            end
            KIND_INS_POS:
            begin
                ins_w = 1'b1;
                p_w   = pos_ext;
                if (full) st_w = STATUS_FULL;
                else if (pos_ext > cnt_ext) st_w = STATUS_RANGE;
            end
            KIND_REM_FRONT:
            begin
                if (empty) st_w = STATUS_EMPTY;
            end
            KIND_REM_END:
            begin
                p_w = cnt_ext - CMPW'(1);
                if (empty) st_w = STATUS_EMPTY;
            end
            KIND_REM_POS:
            begin
                p_w = pos_ext;
                if (empty) st_w = STATUS_EMPTY;
                else if (pos_ext >= cnt_ext) st_w = STATUS_RANGE;
            end
            KIND_READ:
            begin
                p_w = pos_ext;
                if (pos_ext >= cnt_ext) st_w = STATUS_RANGE;
            end
            default:
            begin
            end
        endcase
        // Inserts walk down from the last entry, removes and reads walk up from p.
        start_w = ins_w ? (cnt_ext - CMPW'(1)) : p_w;
        n_w     = (req.data.kind == KIND_READ) ? CMPW'(1) : (cnt_ext - p_w);
        val_wide = WIDE'(req.data.entry_value);
    end

    always_comb
    begin
        op_ins = 1'b0;
        op_rem = 1'b0;
        case (kind_reg) inside
            KIND_INS_FRONT, KIND_INS_END, KIND_INS_POS: op_ins = 1'b1;
            KIND_REM_FRONT, KIND_REM_END, KIND_REM_POS: op_rem = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        ret_valid_next = 1'b0;
        ret_addr_next  = ret_addr_reg;
        got_next       = got_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = ret_addr_reg;
        wr_data        = rd_data;
        got_wide       = WIDE'(got_reg);
        cnt_out_ext    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next    = req.data.kind;
                    pos_next     = p_w[AW-1:0];
                    val_next     = val_wide[ENTRY_WIDTH-1:0];
                    rd_addr_next = start_w[AW-1:0];
                    rd_left_next = n_w[CW-1:0];
                    got_next     = '0;
                    status_next  = st_w;
                    if (st_w == STATUS_OK && req.data.kind != KIND_UNUSED)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // Failed or unused operations leave the list untouched.
                        kind_next  = KIND_UNUSED;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_RUN:
            begin
                if (rd_left_reg != '0)
                begin
                    rd_en          = 1'b1;
                    rd_left_next   = rd_left_reg - CW'(1);
                    rd_addr_next   = op_ins ? (rd_addr_reg - AW'(1)) : (rd_addr_reg + AW'(1));
                    ret_valid_next = 1'b1;
                    ret_addr_next  = rd_addr_reg;
                end
                if (ret_valid_reg)
                begin
                    if (op_ins)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ret_addr_reg + AW'(1);
                    end
                    else if (op_rem && ret_addr_reg != pos_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ret_addr_reg - AW'(1);
                    end
                    else
                    begin
                        got_next = rd_data;
                    end
                end
                else if (rd_left_reg == '0)
                begin
                    if (op_ins)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pos_reg;
                        wr_data = val_reg;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    if (op_ins)      cnt_next = cnt_reg + CW'(1);
                    else if (op_rem) cnt_next = cnt_reg - CW'(1);
                    cnt_out_ext             = CMPW'(cnt_next);
                    out_data_next.status    = status_reg;
                    out_data_next.entry_out = got_wide[VALUE_W-1:0];
                    out_data_next.count     = cnt_out_ext[COUNT_W-1:0];
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_left_reg   <= '0;
            ret_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_UNUSED;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_left_reg   <= rd_left_next;
            ret_valid_reg <= ret_valid_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        rd_addr_reg  <= rd_addr_next;
        ret_addr_reg <= ret_addr_next;
        got_reg      <= got_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // The read pointer leads the trailing write, so one entry is never read and written together.
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds the list depth");

    a_count_moves_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(state_reg) == ST_FIN))
        else $error("entry count changed outside the finish step");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && status_reg != STATUS_OK) |=> ($stable(cnt_reg)))
        else $error("failed operation changed the entry count");
`endif

endmodule

`default_nettype wire

>>> rtl/positional_array_list_unit.sv
// Top level of the positional array list: the entry memory and its sequencer.
// Depends on pal_pkg, pal_if, pal_ram and pal_seq.
`default_nettype none

// The unit keeps an ordered list of up to DEPTH entries in one memory with a
// registered read port and answers each request item with exactly one response
// item giving a status, the removed or read entry, and the count afterward.
// Requests are taken one at a time. An item that moves n entries (entries at
// and past the position for an insert or remove, one for a read) keeps the
// unit busy while those entries are read and written back, then finishes; an
// insert at the end of the list moves nothing. The single memory read port
// moves one entry per cycle; no new request is taken during the walk.
// A rejected item (full, empty or out of range) or an unused kind goes
// straight to the final step. A finished response waits in an output
// register, and the next request is accepted while it waits; that request
// stalls in its final step until the waiting response has been taken.
// Memory contents need no clearing after reset; only positions below the
// count are ever read.
module positional_array_list_unit #(
    parameter int DEPTH       = pal_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pal_req_if.sink    req,
    pal_rsp_if.source  rsp
);

    import pal_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [ENTRY_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;

    // Sequencer: checks each item, walks the shift and builds the response.
    pal_seq #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Entry storage with one read and one write port.
    pal_ram #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire
